// File: rtl/cheb_pkg.sv
// Shared types and constants for the Chebyshev table value block.
// Used by cheb_div, cheb_cell and chebyshev_table_value_top; no dependencies.
`default_nettype none

package cheb_pkg;

  localparam int IDX_W = 10;   // table index
  localparam int LEN_W = 11;   // table length register
  localparam int ORD_W = 5;    // polynomial order register
  localparam int X_W   = 18;   // x and final value, signed Q1.16
  localparam int T_W   = 22;   // recurrence terms, clamped to +-2^20
  localparam int QUO_W = 18;   // quotient bits produced by the divider
  localparam int CNT_W = 5;

  localparam int DIV_STEPS = QUO_W;

  localparam logic signed [X_W-1:0] Q_ONE_X   = 18'sd65536;
  localparam logic signed [T_W-1:0] Q_ONE_T   = 22'sd65536;
  localparam logic signed [T_W-1:0] TERM_LIM  = 22'sd1048576;

  // word addresses of the configuration registers (paddr[2])
  localparam logic ADDR_ORDER  = 1'b0;
  localparam logic ADDR_LENGTH = 1'b1;

  localparam logic [ORD_W-1:0] ORDER_RST  = 5'd1;
  localparam logic [LEN_W-1:0] LENGTH_RST = 11'd1024;

  typedef struct packed {
    logic                  err;
    logic signed [X_W-1:0] x;
    logic signed [T_W-1:0] tprev;
    logic signed [T_W-1:0] tcur;
  } cheb_word_t;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_CALC = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

endpackage : cheb_pkg

`default_nettype wire

// File: rtl/chebyshev_table_value_top.sv
// Chebyshev waveshaping table value: top level with the configuration
// registers, the divider and the chain of recurrence cells.
// Depends on cheb_pkg, cheb_div and cheb_cell.
//
// Usage: write poly_order (address 0) and table_length (address 4) over
// the APB-style port while the block is idle; pready is always high.
// Each word on the in_ channel (in_entry_index) gives exactly one word on
// the out_ channel: out_entry_value, T_n(x) in signed Q1.16 saturated to
// +-1, and out_index_error, set with a zero value when the index is not
// below table_length.
// The divider takes one word at a time: it makes one quotient bit per cycle
// and takes no new word until it has handed its finished word on.
// From acceptance to out_valid a word passes through the divider, then
// MAX_ORDER-1 recurrence cells (at least one) and the output register.
// Reset restores order 1 and length 1024 and empties the pipeline.
// When the receiver stalls the output register holds and the whole cell
// chain holds with it; the divider then holds its finished word and
// in_ready stays low until that word moves on.
`default_nettype none

module chebyshev_table_value_top
  import cheb_pkg::*;
#(
  parameter int MAX_ORDER = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [IDX_W-1:0]      in_entry_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [X_W-1:0]      out_entry_value,
  output logic                       out_index_error
);

  localparam int         NCELLS    = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;
  localparam logic [6:0] MAX_ORD_C = 7'(MAX_ORDER);

  logic [ORD_W-1:0]      order_r;
  logic [LEN_W-1:0]      length_r;
  logic [ORD_W-1:0]      ord_eff;
  logic                  cfg_wr;

  logic                  adv;
  logic                  div_ready;
  logic                  start;
  logic [NCELLS:0]       vld;
  cheb_word_t            wrd [NCELLS+1];

  logic                  out_valid_r;
  logic signed [X_W-1:0] value_r, value_nxt;
  logic                  err_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= ORDER_RST;
      length_r <= LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ADDR_ORDER:  order_r  <= pwdata[ORD_W-1:0];
        ADDR_LENGTH: length_r <= pwdata[LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_ORDER:  prdata = {27'b0, order_r};
      ADDR_LENGTH: prdata = {21'b0, length_r};
      default:     prdata = '0;
    endcase
  end

  assign ord_eff = ({2'b00, order_r} > MAX_ORD_C) ? MAX_ORD_C[ORD_W-1:0] : order_r;

  // the whole chain advances unless the output register is full and stalled
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = div_ready;
  assign start    = in_valid && div_ready;

  cheb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .idx_i   (in_entry_index),
    .len_i   (length_r),
    .ready_o (div_ready),
    .take_i  (adv),
    .valid_o (vld[0]),
    .word_o  (wrd[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    cheb_cell #(
      .STEP (i + 1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv_i   (adv),
      .order_i (ord_eff),
      .valid_i (vld[i]),
      .word_i  (wrd[i]),
      .valid_o (vld[i+1]),
      .word_o  (wrd[i+1])
    );
  end

  always_comb begin
    if (wrd[NCELLS].err) begin
      value_nxt = '0;
    end else if (ord_eff == '0) begin
      value_nxt = Q_ONE_X;
    end else if (wrd[NCELLS].tcur > 22'sd65536) begin
      value_nxt = Q_ONE_X;
    end else if (wrd[NCELLS].tcur < -22'sd65536) begin
      value_nxt = -Q_ONE_X;
    end else begin
      value_nxt = wrd[NCELLS].tcur[X_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld[NCELLS];
    end
    if (adv && vld[NCELLS]) begin
      value_r <= value_nxt;
      err_r   <= wrd[NCELLS].err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = value_r;
  assign out_index_error = err_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("divider took a second word while busy");

  a_div_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    vld[0] && !adv |=> vld[0])
    else $error("finished divider word dropped during stall");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_entry_value == '0)
    else $error("index error word carries a nonzero value");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_value <= 18'sd65536) && (out_entry_value >= -18'sd65536))
    else $error("output value outside plus or minus one");

endmodule : chebyshev_table_value_top

`default_nettype wire

// File: rtl/cheb_div.sv
// Forms x = 2*index/(length-1) - 1 in Q1.16 by a rounded restoring divide,
// one quotient bit per cycle. Depends on cheb_pkg.
`default_nettype none

module cheb_div
  import cheb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [LEN_W-1:0] len_i,
  output logic                  ready_o,
  input  wire logic             take_i,
  output logic                  valid_o,
  output cheb_word_t            word_o
);

  div_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [LEN_W-1:0]   div_r, div_nxt;
  logic               err_r, err_nxt;

  logic [LEN_W-1:0]   div_in;
  logic [27:0]        num;
  logic [LEN_W:0]     trial;
  logic [LEN_W:0]     diff;
  logic               ge;
  logic [X_W:0]       xw;

  always_comb begin
    div_in = (len_i >= 11'd2) ? (len_i - 11'd1) : 11'd1;
    // round to nearest: add half the divisor
    num    = {1'b0, idx_i, 17'b0} + {17'b0, div_in[LEN_W-1:1]};
    trial  = {rem_r, quo_r[QUO_W-1]};
    diff   = trial - {1'b0, div_r};
    ge     = (trial >= {1'b0, div_r});
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    err_nxt   = err_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (start_i) begin
          state_nxt = DIV_CALC;
          cnt_nxt   = '0;
          rem_nxt   = {1'b0, num[27:18]};
          quo_nxt   = num[17:0];
          div_nxt   = div_in;
          err_nxt   = ({1'b0, idx_i} >= len_i);
        end
      end
      DIV_CALC: begin
        rem_nxt = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (take_i) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    err_r <= err_nxt;
  end

  always_comb begin
    xw           = {1'b0, quo_r} - 19'sd65536;
    ready_o      = (state_r == DIV_IDLE);
    valid_o      = (state_r == DIV_DONE);
    word_o.err   = err_r;
    word_o.x     = xw[X_W-1:0];
    word_o.tprev = Q_ONE_T;
    word_o.tcur  = {{(T_W-X_W){xw[X_W-1]}}, xw[X_W-1:0]};
  end

endmodule : cheb_div

`default_nettype wire

// File: rtl/cheb_cell.sv
// One recurrence cell: T(k+1) = round(2x*T(k)) - T(k-1), clamped, registered.
// Passes the word through unchanged when its step lies at or beyond the order.
// Depends on cheb_pkg.
`default_nettype none

module cheb_cell
  import cheb_pkg::*;
#(
  parameter int STEP = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv_i,
  input  wire logic [ORD_W-1:0] order_i,
  input  wire logic             valid_i,
  input  wire cheb_word_t       word_i,
  output logic                  valid_o,
  output cheb_word_t            word_o
);

  localparam logic [6:0] STEP_C = 7'(STEP);

  logic               valid_r;
  cheb_word_t         word_r, word_nxt;
  logic               active;
  logic signed [39:0] prod;
  logic signed [40:0] prod2;
  logic signed [40:0] biased;
  logic signed [24:0] rnd;
  logic signed [25:0] diff;
  logic signed [T_W-1:0] tnext;

  always_comb begin
    active = (STEP_C < {2'b00, order_i});
    prod   = word_i.x * word_i.tcur;
    prod2  = $signed({prod, 1'b0});
    // half rounds upward
    biased = prod2 + 41'sd32768;
    rnd    = biased[40:16];
    diff   = {rnd[24], rnd} - {{(26-T_W){word_i.tprev[T_W-1]}}, word_i.tprev};
    if (diff > 26'sd1048576) begin
      tnext = TERM_LIM;
    end else if (diff < -26'sd1048576) begin
      tnext = -TERM_LIM;
    end else begin
      tnext = diff[T_W-1:0];
    end
    word_nxt = word_i;
    if (active) begin
      word_nxt.tprev = word_i.tcur;
      word_nxt.tcur  = tnext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_i) begin
      valid_r <= valid_i;
    end
    if (adv_i) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule : cheb_cell

`default_nettype wire
